FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent, checked during reset too.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/ps2mct_pkg.sv
// Shared constants, widths and word layouts of the PS/2 mouse cursor tracker.
package ps2mct_pkg;

   // Screen geometry in text cells and fine units per cell.
   localparam int SCREEN_COLS = 80;
   localparam int SCREEN_ROWS = 25;
   localparam int X_STEP      = 8;
   localparam int Y_STEP      = 16;

   localparam int X_LIMIT = SCREEN_COLS * X_STEP;
   localparam int Y_LIMIT = SCREEN_ROWS * Y_STEP;

   // Internal widths at full precision.
   localparam int POS_X_W = $clog2(X_LIMIT + 1);
   localparam int POS_Y_W = $clog2(Y_LIMIT + 1);
   localparam int COL_W   = $clog2(SCREEN_COLS + 1);
   localparam int ROW_W   = $clog2(SCREEN_ROWS + 1);
   localparam int DELTA_W = 9;
   localparam int SUM_X_W = ((POS_X_W > DELTA_W) ? POS_X_W : DELTA_W) + 2;
   localparam int SUM_Y_W = ((POS_Y_W > DELTA_W) ? POS_Y_W : DELTA_W) + 2;

   // Constant division by reciprocal multiply: exact for every value below 2**POS_*_W.
   localparam int    X_DIV_SH = POS_X_W + $clog2(X_STEP);
   localparam int    Y_DIV_SH = POS_Y_W + $clog2(Y_STEP);
   localparam longint X_DIV_M = ((longint'(1) << X_DIV_SH) + X_STEP - 1) / X_STEP;
   localparam longint Y_DIV_M = ((longint'(1) << Y_DIV_SH) + Y_STEP - 1) / Y_STEP;
   localparam int    MUL_X_W = POS_X_W + 2;
   localparam int    MUL_Y_W = POS_Y_W + 2;

   // Header byte layout.
   localparam logic [7:0] HDR_OVERFLOW_MASK = 8'hC0;
   localparam logic [7:0] HDR_ACK           = 8'hFA;
   localparam logic [7:0] HDR_BUTTONS_MASK  = 8'h07;
   localparam int         HDR_ALWAYS_ONE    = 3;
   localparam int         HDR_X_SIGN        = 4;
   localparam int         HDR_Y_SIGN        = 5;

   // Port word widths.
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 48;
   localparam int PTR_X_W    = 10;
   localparam int PTR_Y_W    = 9;
   localparam int OUT_COL_W  = 7;
   localparam int OUT_ROW_W  = 5;

   // One complete movement packet handed from the framer to the tracker.
   typedef struct packed {
      logic               valid;
      logic [DELTA_W-1:0] dx;
      logic [DELTA_W-1:0] dy;
      logic               button;
   } pkt_type;

   // Result word, last field in the lowest bits.
   typedef struct packed {
      logic [2:0]           pad;
      logic                 button_down;
      logic                 cell_changed;
      logic [OUT_ROW_W-1:0] prev_row;
      logic [OUT_COL_W-1:0] prev_col;
      logic [OUT_ROW_W-1:0] cell_row;
      logic [OUT_COL_W-1:0] cell_col;
      logic [PTR_Y_W-1:0]   pointer_y;
      logic [PTR_X_W-1:0]   pointer_x;
   } rsp_data_type;

endpackage

FILE: rtl/ps2mct_frame.sv
// Byte framer: checks the header and assembles three bytes into one movement packet.
module ps2mct_frame (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ps2mct_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                               pkt_take,
   output ps2mct_pkg::pkt_type                pkt
);
   import ps2mct_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_DELTA_X,
      PH_DELTA_Y
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] header_ff, header_in;
   logic [7:0] delta_x_ff, delta_x_in;
   pkt_type    pkt_ff, pkt_in;
   logic       accept;
   logic       header_ok;

   // Header and delta X words never touch the packet register, so they flow even while
   // a finished packet waits.
   assign req_tready = (phase_ff != PH_DELTA_Y) || !pkt_ff.valid || pkt_take;
   assign accept     = req_tvalid && req_tready;
   assign header_ok  = ((req_tdata & HDR_OVERFLOW_MASK) == 8'h00) &&
                       req_tdata[HDR_ALWAYS_ONE] && (req_tdata != HDR_ACK);
   assign pkt        = pkt_ff;

   always_comb begin
      phase_in   = phase_ff;
      header_in  = header_ff;
      delta_x_in = delta_x_ff;
      pkt_in     = pkt_ff;
      if (pkt_take) begin
         pkt_in.valid = 1'b0;
      end
      if (accept) begin
         case (phase_ff)
            PH_DELTA_X: begin
               delta_x_in = req_tdata;
               phase_in   = PH_DELTA_Y;
            end
            PH_DELTA_Y: begin
               phase_in      = PH_HEADER;
               pkt_in.valid  = 1'b1;
               pkt_in.dx     = {header_ff[HDR_X_SIGN], delta_x_ff};
               pkt_in.dy     = {header_ff[HDR_Y_SIGN], req_tdata};
               pkt_in.button = (header_ff & HDR_BUTTONS_MASK) != 8'h00;
            end
            default: begin
               // Header phase; the unused phase code behaves the same way.
               if (header_ok) begin
                  header_in = req_tdata;
                  phase_in  = PH_DELTA_X;
               end else begin
                  phase_in = PH_HEADER;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         header_ff    <= 8'h00;
         delta_x_ff   <= 8'h00;
         pkt_ff.valid <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         header_ff    <= header_in;
         delta_x_ff   <= delta_x_in;
         pkt_ff.valid <= pkt_in.valid;
      end
      pkt_ff.dx     <= pkt_in.dx;
      pkt_ff.dy     <= pkt_in.dy;
      pkt_ff.button <= pkt_in.button;
   end

endmodule

FILE: rtl/ps2mct_track.sv
// Pointer tracker: moves and clamps the position, finds the text cell and holds the result word.
module ps2mct_track (
   input  logic                              clock,
   input  logic                              reset,
   input  ps2mct_pkg::pkt_type               pkt,
   output logic                              pkt_take,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ps2mct_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import ps2mct_pkg::*;

   logic [POS_X_W-1:0] pos_x_ff, pos_x_in;
   logic [POS_Y_W-1:0] pos_y_ff, pos_y_in;
   logic [COL_W-1:0]   shown_col_ff, col_in;
   logic [ROW_W-1:0]   shown_row_ff, row_in;
   logic               rsp_valid_ff;
   rsp_data_type       rsp_data_ff, rsp_data_in;

   logic signed [SUM_X_W-1:0] nx;
   logic signed [SUM_Y_W-1:0] ny;
   logic [2*MUL_X_W-1:0]      prod_x;
   logic [2*MUL_Y_W-1:0]      prod_y;
   logic                      load;

   assign pkt_take   = pkt.valid && (!rsp_valid_ff || rsp_tready);
   assign load       = pkt_take;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      nx = $signed(SUM_X_W'(pos_x_ff)) + $signed({{(SUM_X_W-DELTA_W){pkt.dx[DELTA_W-1]}}, pkt.dx});
      ny = $signed(SUM_Y_W'(pos_y_ff)) - $signed({{(SUM_Y_W-DELTA_W){pkt.dy[DELTA_W-1]}}, pkt.dy});

      if (nx[SUM_X_W-1]) begin
         pos_x_in = '0;
      end else if ($unsigned(nx) >= SUM_X_W'(X_LIMIT)) begin
         pos_x_in = POS_X_W'(X_LIMIT - 1);
      end else begin
         pos_x_in = POS_X_W'($unsigned(nx));
      end

      if (ny[SUM_Y_W-1]) begin
         pos_y_in = '0;
      end else if ($unsigned(ny) >= SUM_Y_W'(Y_LIMIT)) begin
         pos_y_in = POS_Y_W'(Y_LIMIT - 1);
      end else begin
         pos_y_in = POS_Y_W'($unsigned(ny));
      end

      // Cell index is the position divided by the cell size, done as a reciprocal multiply.
      prod_x = (2*MUL_X_W)'(pos_x_in) * (2*MUL_X_W)'(MUL_X_W'(X_DIV_M));
      prod_y = (2*MUL_Y_W)'(pos_y_in) * (2*MUL_Y_W)'(MUL_Y_W'(Y_DIV_M));
      col_in = COL_W'(prod_x >> X_DIV_SH);
      row_in = ROW_W'(prod_y >> Y_DIV_SH);

      rsp_data_in.pad          = '0;
      rsp_data_in.pointer_x    = PTR_X_W'(pos_x_in);
      rsp_data_in.pointer_y    = PTR_Y_W'(pos_y_in);
      rsp_data_in.cell_col     = OUT_COL_W'(col_in);
      rsp_data_in.cell_row     = OUT_ROW_W'(row_in);
      rsp_data_in.prev_col     = OUT_COL_W'(shown_col_ff);
      rsp_data_in.prev_row     = OUT_ROW_W'(shown_row_ff);
      rsp_data_in.cell_changed = (col_in != shown_col_ff) || (row_in != shown_row_ff);
      rsp_data_in.button_down  = pkt.button;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         shown_col_ff <= '0;
         shown_row_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            pos_x_ff     <= pos_x_in;
            pos_y_ff     <= pos_y_in;
            shown_col_ff <= col_in;
            shown_row_ff <= row_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

FILE: rtl/ps2_mouse_cursor_tracker.sv
// Top level of the PS/2 mouse cursor tracker: byte framer followed by the pointer tracker.
// The third byte of a packet goes into the packet register, then its word into the result register on rsp_tdata.
// Throughput: one input byte per cycle while req_tready is high; a packet of three bytes yields one result word.
// The packet register and the result register each take a new word when the next stage frees.
// Synchronous active-high reset returns to the header phase, pointer and cell at zero.
module ps2_mouse_cursor_tracker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // data_byte [7:0]
   input  logic [ps2mct_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // pointer_x [9:0], pointer_y [18:10], cell_col [25:19], cell_row [30:26],
   // prev_col [37:31], prev_row [42:38], cell_changed [43], button_down [44], zero [47:45]
   output logic [ps2mct_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import ps2mct_pkg::*;

   pkt_type pkt;
   logic    pkt_take;

   ps2mct_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .pkt_take   (pkt_take),
      .pkt        (pkt)
   );

   ps2mct_track u_track (
      .clock      (clock),
      .reset      (reset),
      .pkt        (pkt),
      .pkt_take   (pkt_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: rtl/ps2mct_checker.sv
// Port-level checker of the PS/2 mouse cursor tracker and its bind to the top level.
`include "assert_macros.svh"

module ps2mct_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [ps2mct_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import ps2mct_pkg::*;

   rsp_data_type         rsp_view;
   logic [OUT_COL_W-1:0] last_col_ff;
   logic [OUT_ROW_W-1:0] last_row_ff;
   logic                 prev_ok;
   logic                 changed_ok;

   assign rsp_view   = rsp_tdata;
   assign prev_ok    = (rsp_view.prev_col == last_col_ff) && (rsp_view.prev_row == last_row_ff);
   assign changed_ok = rsp_view.cell_changed ==
                       ((rsp_view.cell_col != rsp_view.prev_col) ||
                        (rsp_view.cell_row != rsp_view.prev_row));

   // Cell of the last delivered word; the next word reports it as the previous cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= '0;
         last_row_ff <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         last_col_ff <= rsp_view.cell_col;
         last_row_ff <= rsp_view.cell_row;
      end
   end

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `ASSERT_SAME(a_prev_cell, clock, reset, rsp_tvalid, prev_ok)
   `ASSERT_SAME(a_changed, clock, reset, rsp_tvalid, changed_ok)
   `ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, !rsp_tvalid)
   `ASSERT_NEXT_ALWAYS(a_reset_ready, clock, reset, req_tready)

endmodule

bind ps2_mouse_cursor_tracker ps2mct_checker u_checker (.*);

FILE: tb/tb_ps2_mouse_cursor_tracker.sv
// Self-checking testbench for the PS/2 mouse cursor tracker with random stream pacing.
module tb_ps2_mouse_cursor_tracker;
   import ps2mct_pkg::*;

   localparam int QUIET_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 8;
   localparam int STREAM_BYTES = 1375;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_DELTA_X,
      PH_DELTA_Y
   } phase_type;

   // Opening bytes: rejected headers of every kind, then packets that drive both
   // axes into both screen edges and press each button.
   localparam logic [7:0] OPENING_BYTES [25] = '{
      8'hC8, 8'h48, 8'h07, 8'hFA,
      8'h08, 8'h00, 8'h00,
      8'h09, 8'hFF, 8'h80,
      8'h2A, 8'hFF, 8'h00,
      8'h2C, 8'hFA, 8'h00,
      8'h18, 8'h00, 8'h01,
      8'h3F, 8'h00, 8'hFF,
      8'h18, 8'h01, 8'h7F
   };

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic [7:0]   mouse_bytes[$];
   rsp_data_type expected_moves[$];

   // Mirror of the tracker state, at its reset values.
   phase_type  phase     = PH_HEADER;
   logic [7:0] held_hdr  = '0;
   logic [7:0] held_dx   = '0;
   int         cur_x     = 0;
   int         cur_y     = 0;
   int         shown_col = 0;
   int         shown_row = 0;

   int errors      = 0;
   int quiet_count = 0;
   int send_gap    = 0;
   int recv_stall  = 0;
   bit burst       = 1'b0;
   bit byte_taken  = 1'b0;

   ps2_mouse_cursor_tracker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Advances the mirrored framer by one byte and queues the movement word that a
   // completed packet produces.
   task automatic track_byte(input logic [7:0] b);
      int           dx;
      int           dy;
      int           nx;
      int           ny;
      int           col;
      int           row;
      rsp_data_type move;
      case (phase)
         PH_DELTA_X: begin
            held_dx = b;
            phase = PH_DELTA_Y;
         end
         PH_DELTA_Y: begin
            phase = PH_HEADER;
            dx = int'(held_dx) - (held_hdr[HDR_X_SIGN] ? 256 : 0);
            dy = int'(b) - (held_hdr[HDR_Y_SIGN] ? 256 : 0);
            nx = cur_x + dx;
            ny = cur_y - dy;
            cur_x = (nx < 0) ? 0 : (nx >= X_LIMIT) ? X_LIMIT - 1 : nx;
            cur_y = (ny < 0) ? 0 : (ny >= Y_LIMIT) ? Y_LIMIT - 1 : ny;
            col = cur_x / X_STEP;
            row = cur_y / Y_STEP;
            move = '0;
            move.pointer_x    = PTR_X_W'(cur_x);
            move.pointer_y    = PTR_Y_W'(cur_y);
            move.cell_col     = OUT_COL_W'(col);
            move.cell_row     = OUT_ROW_W'(row);
            move.prev_col     = OUT_COL_W'(shown_col);
            move.prev_row     = OUT_ROW_W'(shown_row);
            move.cell_changed = (col != shown_col) || (row != shown_row);
            move.button_down  = |(held_hdr & HDR_BUTTONS_MASK);
            shown_col = col;
            shown_row = row;
            expected_moves.push_back(move);
         end
         default: begin
            if ((b & HDR_OVERFLOW_MASK) == '0 && b[HDR_ALWAYS_ONE] && b != HDR_ACK) begin
               held_hdr = b;
               phase = PH_DELTA_X;
            end else begin
               phase = PH_HEADER;
            end
         end
      endcase
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // Queues one packet, without its dy byte when truncated; gentle packets move by a
   // few units so that the cell often stays the same.
   task automatic add_packet(input bit gentle, input bit truncated);
      logic [8:0] dx;
      logic [8:0] dy;
      logic [2:0] keys;
      if (gentle) begin
         dx = 9'($urandom_range(0, 14) - 7);
         dy = 9'($urandom_range(0, 14) - 7);
      end else begin
         dx = 9'($urandom_range(0, 511));
         dy = 9'($urandom_range(0, 511));
      end
      keys = 3'($urandom_range(0, 7));
      mouse_bytes.push_back({2'b00, dy[8], dx[8], 1'b1, keys});
      mouse_bytes.push_back(dx[7:0]);
      if (!truncated) mouse_bytes.push_back(dy[7:0]);
   endtask

   task automatic add_bad_header();
      logic [7:0] b;
      b = 8'($urandom);
      case ($urandom_range(0, 2))
         0: b = HDR_ACK;
         1: b[7:6] = 2'($urandom_range(1, 3));
         default: b[HDR_ALWAYS_ONE] = 1'b0;
      endcase
      mouse_bytes.push_back(b);
   endtask

   always @(negedge clock) begin : driver
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if ($urandom_range(0, 199) == 0) burst = !burst;
         if (!req_tvalid || byte_taken) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (mouse_bytes.size() > 0) begin
               req_tdata  <= mouse_bytes.pop_front();
               req_tvalid <= 1'b1;
               send_gap = pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            recv_stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin : monitor
      rsp_data_type got;
      rsp_data_type want;
      byte_taken = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_moves.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %h", $time, rsp_tdata);
               errors++;
            end else begin
               want = expected_moves.pop_front();
               check_field("pointer_x", want.pointer_x, got.pointer_x);
               check_field("pointer_y", want.pointer_y, got.pointer_y);
               check_field("cell_col", want.cell_col, got.cell_col);
               check_field("cell_row", want.cell_row, got.cell_row);
               check_field("prev_col", want.prev_col, got.prev_col);
               check_field("prev_row", want.prev_row, got.prev_row);
               check_field("cell_changed", want.cell_changed, got.cell_changed);
               check_field("button_down", want.button_down, got.button_down);
               check_field("pad", want.pad, got.pad);
            end
         end
         if (req_tvalid && req_tready) begin
            byte_taken = 1'b1;
            track_byte(req_tdata);
         end
         if (byte_taken || (rsp_tvalid && rsp_tready)) quiet_count = 0;
         else quiet_count++;
      end
   end

   initial begin : watchdog
      while (quiet_count < QUIET_LIMIT) @(posedge clock);
      $display("tb_ps2_mouse_cursor_tracker: FAIL");
      $finish;
   end

   initial begin : stimulus
      int r;
      foreach (OPENING_BYTES[i]) mouse_bytes.push_back(OPENING_BYTES[i]);
      while (mouse_bytes.size() < STREAM_BYTES) begin
         r = $urandom_range(0, 19);
         if (r < 16) add_packet(r < 5, 1'b0);
         else if (r == 16) add_bad_header();
         else if (r == 17) add_packet(1'b0, 1'b1);
         else mouse_bytes.push_back(8'($urandom));
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (mouse_bytes.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_moves.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("tb_ps2_mouse_cursor_tracker: PASS");
      end else begin
         $display("tb_ps2_mouse_cursor_tracker: FAIL");
      end
      $finish;
   end

endmodule

FILE: ps2_mouse_cursor_tracker.f
+incdir+rtl
rtl/ps2mct_pkg.sv
rtl/ps2mct_frame.sv
rtl/ps2mct_track.sv
rtl/ps2_mouse_cursor_tracker.sv
rtl/ps2mct_checker.sv
tb/tb_ps2_mouse_cursor_tracker.sv
